// ----- hw/rtl/vdu_pkg.sv -----
// vdu_pkg: widths, stream layout and result type of the 3d distance unit
// no dependencies; imported by vector3_distance_unit_top

package vdu_pkg;

    // coordinate width actually used, and the fixed width of each field on the bus
    localparam int COORD_BITS    = 31;
    localparam int FIELD_BITS    = 31;
    localparam int NUM_AXES      = 3;
    localparam int NUM_IN_FIELDS = 2 * NUM_AXES;

    localparam int IN_DATA_BITS  = ((NUM_IN_FIELDS * FIELD_BITS + 7) / 8) * 8;

    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int SUM_BITS      = 64;
    localparam int ROOT_BITS     = SUM_BITS / 2;
    localparam int ROOT_STEPS    = ROOT_BITS;
    localparam int REM_BITS      = ROOT_BITS + 1;

    localparam int OUT_DATA_BITS = ((SUM_BITS + ROOT_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] mag_t;
    typedef logic [SQ_BITS-1:0]    square_t;
    typedef logic [SUM_BITS-1:0]   sum_t;
    typedef logic [ROOT_BITS-1:0]  root_t;
    typedef logic [REM_BITS-1:0]   rem_t;

    // packed low to high: distance_squared, distance
    typedef struct packed {
        root_t distance;
        sum_t  distance_squared;
    } result_t;

endpackage

// ----- hw/rtl/vector3_distance_unit_top.sv -----
// vector3_distance_unit_top: pipelined exact 3d distance with integer square root
// depends on vdu_pkg

// usage
//   slave stream s_axis_*: one beat carries a point and a reference point, six
//   signed coordinates; the master stream m_axis_* returns one beat per input
//   beat with the exact squared distance and its floor square root, in order
//   path: an accepted beat reaches m_axis_tvalid through 36 registers (abs
//   difference, square, sum, 32 root steps, output register), the first
//   loaded at the accepting edge
//   throughput: one beat per cycle when not stalled; the root is a chain of 32
//   registered steps, one result bit each, so every stage is one 35-bit
//   compare and subtract and the three squares sit in their own stage
//   stall: a two-entry output buffer (output register plus skid register)
//   sits behind the pipeline; the pipeline and s_axis_tready hold only once
//   the skid register is full, so a new beat is still taken while a finished
//   result waits on m_axis_tready, and nothing is lost or repeated
//   s_axis_tready is driven straight from a register
//   reset: asynchronous, active low; clears all valid bits and the output
//   buffer, the block keeps no other state and needs no clearing pass
//   only the low COORD_BITS bits of each coordinate field are used,
//   sign-extended from the top one of them

module vector3_distance_unit_top
    import vdu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // point_x, point_y, point_z, origin_x, origin_y, origin_z, zero pad
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // distance_squared, distance
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    // global advance: the whole pipeline moves unless the skid register is full
    logic adv;

    // stage 1: absolute component differences
    logic [COORD_BITS:0] diff   [NUM_AXES];
    logic [COORD_BITS:0] negd   [NUM_AXES];
    mag_t                mag_next [NUM_AXES];
    mag_t                mag_reg  [NUM_AXES];
    logic                mag_valid_reg;

    // stage 2: squares
    square_t             sq_next [NUM_AXES];
    square_t             sq_reg  [NUM_AXES];
    logic                sq_valid_reg;

    // stage 3: sum of squares
    sum_t                sum_next;
    sum_t                sum_reg;
    logic                sum_valid_reg;

    // root stages, one result bit per stage
    logic                rt_valid_next [ROOT_STEPS];
    sum_t                rt_sum_next   [ROOT_STEPS];
    rem_t                rt_rem_next   [ROOT_STEPS];
    root_t               rt_root_next  [ROOT_STEPS];
    logic                rt_valid_reg  [ROOT_STEPS];
    sum_t                rt_sum_reg    [ROOT_STEPS];
    rem_t                rt_rem_reg    [ROOT_STEPS];
    root_t               rt_root_reg   [ROOT_STEPS];

    // output buffer
    result_t             pipe_result;
    logic                push;
    logic                pop;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic                out_load_pipe;
    logic                out_load_skid;
    logic                skid_load;
    result_t             out_data_reg;
    result_t             skid_data_reg;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    // ---------------------------------------------------------------- stage 1
    // difference of two sign-extended coordinates fits COORD_BITS+1 bits,
    // its magnitude fits COORD_BITS bits
    always_comb
    begin
        for (int c = 0; c < NUM_AXES; c++)
        begin
            diff[c] = {s_axis_tdata[c*FIELD_BITS + COORD_BITS - 1],
                       s_axis_tdata[c*FIELD_BITS +: COORD_BITS]}
                    - {s_axis_tdata[(c+NUM_AXES)*FIELD_BITS + COORD_BITS - 1],
                       s_axis_tdata[(c+NUM_AXES)*FIELD_BITS +: COORD_BITS]};
            negd[c] = ~diff[c] + {{COORD_BITS{1'b0}}, 1'b1};
            mag_next[c] = diff[c][COORD_BITS] ? negd[c][COORD_BITS-1:0]
                                              : diff[c][COORD_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        for (int c = 0; c < NUM_AXES; c++)
        begin
            sq_next[c] = SQ_BITS'(mag_reg[c]) * SQ_BITS'(mag_reg[c]);
        end
    end

    // ---------------------------------------------------------------- stage 3
    // three squares of at most COORD_BITS bits each never carry out of 64 bits
    assign sum_next = SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);

    // ---------------------------------------------------------------- root
    // restoring digit recurrence: bring down two bits of the radicand, try
    // subtracting 4*root+1, the outcome is the next root bit
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        logic                src_valid;
        sum_t                src_sum;
        rem_t                src_rem;
        root_t               src_root;
        logic [REM_BITS+1:0] rem_shift;
        logic [REM_BITS+1:0] trial;
        logic [REM_BITS+1:0] rem_sub;
        logic                take;

        if (k == 0)
        begin : g_first
            assign src_valid = sum_valid_reg;
            assign src_sum   = sum_reg;
            assign src_rem   = '0;
            assign src_root  = '0;
        end
        else
        begin : g_chain
            assign src_valid = rt_valid_reg[k-1];
            assign src_sum   = rt_sum_reg[k-1];
            assign src_rem   = rt_rem_reg[k-1];
            assign src_root  = rt_root_reg[k-1];
        end

        assign rem_shift = {src_rem, src_sum[SUM_BITS-1-2*k -: 2]};
        assign trial     = (REM_BITS+2)'({src_root, 2'b01});
        assign rem_sub   = rem_shift - trial;
        assign take      = (rem_shift >= trial);

        // remainder never exceeds twice the partial root, so REM_BITS hold it
        assign rt_valid_next[k] = src_valid;
        assign rt_sum_next[k]   = src_sum;
        assign rt_rem_next[k]   = take ? rem_sub[REM_BITS-1:0] : rem_shift[REM_BITS-1:0];
        assign rt_root_next[k]  = {src_root[ROOT_BITS-2:0], take};
    end

    // ---------------------------------------------------------------- pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                rt_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            mag_valid_reg <= s_axis_tvalid;
            sq_valid_reg  <= mag_valid_reg;
            sum_valid_reg <= sq_valid_reg;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                rt_valid_reg[k] <= rt_valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                mag_reg[c] <= mag_next[c];
                sq_reg[c]  <= sq_next[c];
            end
            sum_reg <= sum_next;
            for (int k = 0; k < ROOT_STEPS; k++)
            begin
                rt_sum_reg[k]  <= rt_sum_next[k];
                rt_rem_reg[k]  <= rt_rem_next[k];
                rt_root_reg[k] <= rt_root_next[k];
            end
        end
    end

    // ---------------------------------------------------------------- output buffer
    assign pipe_result.distance_squared = rt_sum_reg[ROOT_STEPS-1];
    assign pipe_result.distance         = rt_root_reg[ROOT_STEPS-1];

    assign push = rt_valid_reg[ROOT_STEPS-1] && adv;
    assign pop  = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_pipe   = 1'b0;
        out_load_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            // pipeline is frozen, drain the skid beat first
            if (pop)
            begin
                out_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = push;
            out_load_pipe  = push;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (out_load_pipe)
        begin
            out_data_reg <= pipe_result;
        end
        if (skid_load)
        begin
            skid_data_reg <= pipe_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_data_reg);

    // ---------------------------------------------------------------- checks
`ifndef SYNTH
    // the skid register only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a frozen pipeline keeps its last beat intact
    a_tail_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && rt_valid_reg[ROOT_STEPS-1]) |=>
        (rt_valid_reg[ROOT_STEPS-1] && $stable(rt_sum_reg[ROOT_STEPS-1])
         && $stable(rt_root_reg[ROOT_STEPS-1])))
        else $error("pipeline tail changed while stalled");

    // the presented root is the floor square root of the presented sum
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        ((({{(SUM_BITS+2-ROOT_BITS){1'b0}}, out_data_reg.distance})
          * ({{(SUM_BITS+2-ROOT_BITS){1'b0}}, out_data_reg.distance}))
          <= {2'b00, out_data_reg.distance_squared})
        && ((({{(SUM_BITS+2-ROOT_BITS){1'b0}}, out_data_reg.distance}) + 1'b1)
          * (({{(SUM_BITS+2-ROOT_BITS){1'b0}}, out_data_reg.distance}) + 1'b1)
          > {2'b00, out_data_reg.distance_squared}))
        else $error("distance is not the floor root of distance_squared");
`endif

endmodule
